/* design/ct_pkg.sv */
package ct_pkg;

  localparam int unsigned CharWidth = 8;
  localparam int unsigned PartWidth = 16;
  localparam int unsigned OffsetWidth = 16;
  localparam int unsigned QueueDepth = 4;

  localparam logic [1:0] KIND_AMINO = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_DISCARD = 2'd2;

  localparam logic [1:0] REG_FULL_MODE = 2'd0;
  localparam logic [1:0] REG_START_OFFSET = 2'd1;

  localparam logic [1:0] BASE_U = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_A = 2'd2;
  localparam logic [1:0] BASE_G = 2'd3;

  localparam logic [CharWidth-1:0] STOP_MARK = "Z";
  localparam logic [PartWidth-1:0] PART_MAX = '1;

  // index = first*16 + second*4 + third, U C A G = 0 1 2 3
  localparam logic [8*64-1:0] CODE_TABLE =
    "FFLLSSSSYYZZCCZWLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";

  typedef struct packed {
    logic [1:0]           kind;
    logic [CharWidth-1:0] letter;
    logic [PartWidth-1:0] part;
    logic                 done;
  } result_t;

  typedef struct packed {
    logic       bad;
    logic [1:0] code;
  } base_t;

  function automatic logic [CharWidth-1:0] amino_of(input logic [5:0] idx);
    logic [8:0] pos;
    pos = {6'd63 - idx, 3'b000};
    return CODE_TABLE[pos +: 8];
  endfunction

  function automatic base_t base_of(input logic [CharWidth-1:0] c);
    logic [CharWidth-1:0] u;
    base_t b;
    u = c;
    if (c >= "a" && c <= "z") begin
      u = c - 8'd32;
    end
    b.bad = 1'b0;
    b.code = BASE_U;
    case (u)
      "T", "U": b.code = BASE_U;
      "C": b.code = BASE_C;
      "A": b.code = BASE_A;
      "G": b.code = BASE_G;
      default: b.bad = 1'b1;
    endcase
    return b;
  endfunction

endpackage

/* design/codon_translator.sv */
// Codon translator: one nucleotide character is taken per cycle and decoded in the
// same cycle into at most two results, which enter a four-entry result queue; the
// output side delivers one result per cycle while out_stall is low. Input stalls
// only while the queue has fewer than two free slots, so the sustained rate is one
// character per cycle. An end-of-sequence character completing a codon can push two
// results. full_mode and start_offset must be written between sequences, which the
// block does not enforce; characters before start_offset are skipped in each sequence.
module codon_translator
  import ct_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CharWidth-1:0]   nucleotide_char,
  input  logic                   end_of_sequence,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             result_kind,
  output logic [CharWidth-1:0]   amino_letter,
  output logic [PartWidth-1:0]   part_number,
  output logic                   sequence_done,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [OffsetWidth-1:0] cfg_data
);

  localparam int unsigned PtrWidth = $clog2(DEPTH);
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);

  logic                   full_mode;
  logic [OffsetWidth-1:0] start_offset;

  logic [OffsetWidth-1:0] skip_count, skip_count_next;
  logic [1:0]             codon_phase, codon_phase_next;
  logic [5:0]             codon_bits, codon_bits_next;
  logic                   codon_bad, codon_bad_next;
  logic [PartWidth-1:0]   part_index, part_index_next;
  logic                   first_stop_seen, first_stop_seen_next;

  result_t               queue [DEPTH];
  logic [PtrWidth-1:0]   wr_ptr, rd_ptr;
  logic [CntWidth-1:0]   count;

  logic                  in_xfer, out_xfer;
  base_t                 base;
  logic                  skipping, complete, emit, is_stop;
  logic [5:0]            bits_new;
  logic                  bad_new;
  logic [CharWidth-1:0]  aa;
  logic                  end_emit;
  result_t               r_codon, r_end, w0, w1;
  logic [1:0]            push;

  assign in_stall = count > CntWidth'(DEPTH - 2);
  assign in_xfer = in_valid && !in_stall;
  assign out_valid = count != '0;
  assign out_xfer = out_valid && !out_stall;

  assign result_kind = queue[rd_ptr].kind;
  assign amino_letter = queue[rd_ptr].letter;
  assign part_number = queue[rd_ptr].part;
  assign sequence_done = queue[rd_ptr].done;

  always_comb begin
    base = base_of(nucleotide_char);
    skipping = skip_count < start_offset;
    bad_new = codon_bad | base.bad;
    bits_new = base.bad ? codon_bits : {codon_bits[3:0], base.code};
    complete = !skipping && codon_phase == 2'd2;
    aa = amino_of(bits_new);
    is_stop = aa == STOP_MARK;
    emit = complete && !bad_new && (full_mode || !first_stop_seen);

    skip_count_next = skip_count;
    codon_phase_next = codon_phase;
    codon_bits_next = codon_bits;
    codon_bad_next = codon_bad;
    part_index_next = part_index;
    first_stop_seen_next = first_stop_seen;

    if (skipping) begin
      skip_count_next = skip_count + 1'b1;
    end else if (complete) begin
      codon_phase_next = 2'd0;
      codon_bits_next = '0;
      codon_bad_next = 1'b0;
    end else begin
      codon_phase_next = codon_phase + 1'b1;
      codon_bits_next = bits_new;
      codon_bad_next = bad_new;
    end

    r_codon.kind = is_stop ? KIND_CLOSE : KIND_AMINO;
    r_codon.letter = is_stop ? '0 : aa;
    r_codon.part = part_index;
    r_codon.done = end_of_sequence && !(end_of_sequence && (full_mode || !first_stop_seen_next));

    if (emit && is_stop) begin
      if (part_index != PART_MAX) begin
        part_index_next = part_index + 1'b1;
      end
      if (!full_mode) begin
        first_stop_seen_next = 1'b1;
      end
    end

    end_emit = end_of_sequence && (full_mode || !first_stop_seen_next);
    r_codon.done = end_of_sequence && !end_emit;
    r_end.kind = full_mode ? KIND_CLOSE : KIND_DISCARD;
    r_end.letter = '0;
    r_end.part = part_index_next;
    r_end.done = 1'b1;

    w0 = emit ? r_codon : r_end;
    w1 = r_end;
    push = {1'b0, emit} + {1'b0, end_emit};

    if (end_of_sequence) begin
      skip_count_next = '0;
      codon_phase_next = 2'd0;
      codon_bits_next = '0;
      codon_bad_next = 1'b0;
      part_index_next = '0;
      first_stop_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full_mode <= 1'b0;
      start_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FULL_MODE: full_mode <= cfg_data[0];
        REG_START_OFFSET: start_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count <= '0;
      codon_phase <= 2'd0;
      codon_bits <= '0;
      codon_bad <= 1'b0;
      part_index <= '0;
      first_stop_seen <= 1'b0;
    end else if (in_xfer) begin
      skip_count <= skip_count_next;
      codon_phase <= codon_phase_next;
      codon_bits <= codon_bits_next;
      codon_bad <= codon_bad_next;
      part_index <= part_index_next;
      first_stop_seen <= first_stop_seen_next;
    end
  end

  // result queue, up to two writes per transfer
  always_ff @(posedge clk) begin
    if (in_xfer && push != 2'd0) begin
      queue[wr_ptr] <= w0;
      if (push == 2'd2) begin
        queue[wr_ptr + 1'b1] <= w1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (in_xfer) begin
        wr_ptr <= wr_ptr + PtrWidth'(push);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (in_xfer ? CntWidth'(push) : CntWidth'(0))
             - CntWidth'(out_xfer);
    end
  end

endmodule

/* tb/tb_codon_translator.sv */
module tb_codon_translator;
  timeunit 1ns;
  timeprecision 1ps;

  import ct_pkg::*;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned EndWaitLimit = 20_000;
  localparam int BadBase = 4;
  localparam logic [1:0] REG_SPARE_LOW = 2'd2;
  localparam logic [1:0] REG_SPARE_HIGH = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [CharWidth-1:0]   nucleotide_char = '0;
  logic                   end_of_sequence = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             result_kind;
  logic [CharWidth-1:0]   amino_letter;
  logic [PartWidth-1:0]   part_number;
  logic                   sequence_done;
  logic                   cfg_we = 1'b0;
  logic [1:0]             cfg_index = '0;
  logic [OffsetWidth-1:0] cfg_data = '0;

  string amino_table = "FFLLSSSSYYZZCCZWLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
  string base_letters = "UCAG";
  string stop_codons[3] = '{"UAA", "UAG", "UGA"};

  result_t     expected_results[$];
  result_t     oldest_result;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  bit          idle_on = 1'b0;
  int unsigned long_hold_req = 0;
  int unsigned stall_left = 0;

  // translator state as the testbench sees it
  logic                   pred_full_mode = 1'b0;
  logic [OffsetWidth-1:0] pred_offset = '0;
  logic [OffsetWidth-1:0] skip_cnt = '0;
  int unsigned            codon_pos = 0;
  logic [5:0]             codon_acc = '0;
  logic                   codon_has_bad = 1'b0;
  logic [PartWidth-1:0]   part_idx = '0;
  logic                   stop_seen = 1'b0;

  codon_translator i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .nucleotide_char (nucleotide_char),
    .end_of_sequence (end_of_sequence),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_kind     (result_kind),
    .amino_letter    (amino_letter),
    .part_number     (part_number),
    .sequence_done   (sequence_done),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int base_code(input logic [CharWidth-1:0] ch);
    logic [CharWidth-1:0] up;
    up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    case (up)
      "T", "U": return int'(BASE_U);
      "C": return int'(BASE_C);
      "A": return int'(BASE_A);
      "G": return int'(BASE_G);
      default: return BadBase;
    endcase
  endfunction

  task automatic predict_char(input logic [CharWidth-1:0] ch, input logic eos);
    result_t step_results[$];
    int code;
    logic [CharWidth-1:0] aa;
    if (skip_cnt < pred_offset) begin
      skip_cnt++;
    end else begin
      code = base_code(ch);
      if (code == BadBase) begin
        codon_has_bad = 1'b1;
      end else begin
        codon_acc = {codon_acc[3:0], code[1:0]};
      end
      codon_pos++;
      if (codon_pos == 3) begin
        if (!codon_has_bad && (pred_full_mode || !stop_seen)) begin
          aa = amino_table.getc(int'(codon_acc));
          if (aa == STOP_MARK) begin
            step_results.insert(step_results.size(), '{KIND_CLOSE, 8'h00, part_idx, 1'b0});
            if (part_idx != PART_MAX) part_idx++;
            if (!pred_full_mode) stop_seen = 1'b1;
          end else begin
            step_results.insert(step_results.size(), '{KIND_AMINO, aa, part_idx, 1'b0});
          end
        end
        codon_pos = 0;
        codon_acc = '0;
        codon_has_bad = 1'b0;
      end
    end
    if (eos) begin
      if (pred_full_mode) begin
        step_results.insert(step_results.size(), '{KIND_CLOSE, 8'h00, part_idx, 1'b0});
      end else if (!stop_seen) begin
        step_results.insert(step_results.size(), '{KIND_DISCARD, 8'h00, part_idx, 1'b0});
      end
      if (step_results.size() > 0) step_results[step_results.size()-1].done = 1'b1;
      skip_cnt = '0;
      codon_pos = 0;
      codon_acc = '0;
      codon_has_bad = 1'b0;
      part_idx = '0;
      stop_seen = 1'b0;
    end
    foreach (step_results[i]) expected_results.insert(expected_results.size(), step_results[i]);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // result side: checks each transfer and drives the stall pattern
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual kind %0d letter %h part %0d",
                 $time, result_kind, amino_letter, part_number);
        mismatch_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("result_kind", oldest_result.kind, result_kind);
        check_field("amino_letter", oldest_result.letter, amino_letter);
        check_field("part_number", oldest_result.part, part_number);
        check_field("sequence_done", oldest_result.done, sequence_done);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (long_hold_req > 0) begin
      stall_left = long_hold_req - 1;
      long_hold_req = 0;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_char(input logic [CharWidth-1:0] ch, input logic eos);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    nucleotide_char <= ch;
    end_of_sequence <= eos;
    predict_char(ch, eos);
    items_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s.getc(i), close && (i == s.len() - 1));
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [OffsetWidth-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FULL_MODE) begin
      pred_full_mode = value[0];
    end else if (idx == REG_START_OFFSET) begin
      pred_offset = value;
    end
    @(posedge clk);
  endtask

  function automatic logic [CharWidth-1:0] random_char();
    string letters;
    letters = "ACGTUacgtu";
    if ($urandom_range(0, 9) == 0) return CharWidth'($urandom_range(0, 255));
    return letters.getc($urandom_range(0, 9));
  endfunction

  function automatic logic [CharWidth-1:0] vary_letter(input logic [CharWidth-1:0] c);
    logic [CharWidth-1:0] v;
    v = c;
    if (v == "U" && $urandom_range(0, 1) == 1) v = "T";
    if ($urandom_range(0, 2) == 0) v = v + 8'd32;
    return v;
  endfunction

  task automatic send_random_sequence();
    logic [CharWidth-1:0] seq[$];
    int unsigned lead;
    int unsigned n_codons;
    string codon;
    lead = pred_offset;
    if ($urandom_range(0, 4) == 0) lead = $urandom_range(0, pred_offset + 2);
    repeat (lead) seq.insert(seq.size(), random_char());
    n_codons = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(2, 12);
    repeat (n_codons) begin
      if ($urandom_range(0, 7) == 0) begin
        codon = stop_codons[$urandom_range(0, 2)];
        for (int k = 0; k < 3; k++) seq.insert(seq.size(), vary_letter(codon.getc(k)));
      end else begin
        repeat (3) seq.insert(seq.size(), random_char());
      end
    end
    repeat ($urandom_range(0, 2)) seq.insert(seq.size(), random_char());
    if (seq.size() == 0) seq.insert(seq.size(), random_char());
    foreach (seq[i]) send_char(seq[i], i == seq.size() - 1);
  endtask

  task automatic test_reset_state();
    idle_on = 1'b1;
    send_text("AUGGCCUUU", 1'b1);
    send_text("augtgaccc", 1'b1);
    wait_idle();
  endtask

  task automatic test_short_sequences();
    send_text("A", 1'b1);
    send_text("Gc", 1'b1);
    wait_idle();
    write_reg(REG_FULL_MODE, 16'd1);
    send_text("u", 1'b1);
    send_text("CA", 1'b1);
    wait_idle();
  endtask

  task automatic test_full_mode();
    write_reg(REG_FULL_MODE, 16'd1);
    send_text("UAAUAGUGAGCA", 1'b1);
    send_text("CCCtaaAG", 1'b1);
    wait_idle();
    write_reg(REG_FULL_MODE, 16'd0);
    send_text("GGGUAGAAAUAAC", 1'b1);
    wait_idle();
  endtask

  task automatic test_foreign_bytes();
    write_reg(REG_FULL_MODE, 16'd1);
    send_text("NCC", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b0);
    send_text("ccc", 1'b0);
    send_char(8'h7F, 1'b0);
    send_text("xz", 1'b0);
    send_text("uGg", 1'b1);
    wait_idle();
  endtask

  task automatic test_all_codons();
    idle_on = 1'b0;
    write_reg(REG_FULL_MODE, 16'd1);
    for (int idx = 0; idx < 64; idx++) begin
      send_char(base_letters.getc(idx / 16), 1'b0);
      send_char(base_letters.getc((idx / 4) % 4), 1'b0);
      send_char(base_letters.getc(idx % 4), idx == 63);
    end
    wait_idle();
  endtask

  task automatic test_start_offset();
    idle_on = 1'b1;
    write_reg(REG_FULL_MODE, 16'd0);
    write_reg(REG_START_OFFSET, 16'd2);
    send_text("xxAUGCC", 1'b1);
    wait_idle();
    write_reg(REG_START_OFFSET, 16'd5);
    send_text("ACG", 1'b1);
    wait_idle();
  endtask

  task automatic test_offset_change_in_sequence();
    write_reg(REG_FULL_MODE, 16'd0);
    write_reg(REG_START_OFFSET, 16'd20);
    send_text("GATTAC", 1'b0);
    wait_idle();
    // skipping ends at once when the offset drops below the count
    write_reg(REG_START_OFFSET, 16'd3);
    send_text("AUGUAAUUU", 1'b0);
    wait_idle();
    write_reg(REG_FULL_MODE, 16'd1);
    send_text("GGGCC", 1'b1);
    wait_idle();
    write_reg(REG_START_OFFSET, 16'd0);
  endtask

  task automatic test_unused_index();
    write_reg(REG_FULL_MODE, 16'd1);
    write_reg(REG_SPARE_LOW, 16'hFFFF);
    write_reg(REG_SPARE_HIGH, 16'h5A5A);
    send_text("AAAUGG", 1'b1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    write_reg(REG_FULL_MODE, 16'd1);
    long_hold_req = 80;
    repeat (20) send_text("GCU", 1'b0);
    send_text("UAGGG", 1'b1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned phase_end;
    stop_at = items_sent + 1050;
    while (items_sent < stop_at) begin
      wait_idle();
      write_reg(REG_FULL_MODE, OffsetWidth'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0) begin
        write_reg(REG_START_OFFSET, OffsetWidth'($urandom_range(0, 40)));
      end else begin
        write_reg(REG_START_OFFSET, OffsetWidth'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 5) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_LOW : REG_SPARE_HIGH,
                  OffsetWidth'($urandom_range(0, 65535)));
      end
      idle_on = ($urandom_range(0, 3) != 0);
      phase_end = items_sent + $urandom_range(40, 120);
      while (items_sent < phase_end) send_random_sequence();
    end
    // last stretch runs without idling on either side
    wait_idle();
    idle_on = 1'b0;
    write_reg(REG_FULL_MODE, OffsetWidth'($urandom_range(0, 1)));
    write_reg(REG_START_OFFSET, OffsetWidth'($urandom_range(0, 2)));
    stop_at = items_sent + 200;
    while (items_sent < stop_at) send_random_sequence();
  endtask

  initial begin
    int unsigned waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_short_sequences();
    test_full_mode();
    test_foreign_bytes();
    test_all_codons();
    test_start_offset();
    test_offset_change_in_sequence();
    test_unused_index();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < EndWaitLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results expected but never seen", $time, expected_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
